/* src/adaptive_operator_roulette_selector_defines.svh */
// Assertion macros shared by the checker of the operator roulette selector
`ifndef ADAPTIVE_OPERATOR_ROULETTE_SELECTOR_DEFINES_SVH
`define ADAPTIVE_OPERATOR_ROULETTE_SELECTOR_DEFINES_SVH

// same-cycle implication, held off during reset
`define AORS_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("aors check failed");

// next-cycle implication, held off during reset
`define AORS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("aors check failed");

`endif

/* src/aors_pkg.sv */
// Types, constants and codes of the adaptive operator roulette selector
`default_nettype none
package aors_pkg;

  localparam int OPS_PER_GROUP_DEF = 4;
  localparam int GROUP_COUNT_DEF   = 3;
  localparam int SUCCESS_KINDS_DEF = 3;
  localparam int TALLY_WIDTH_DEF   = 24;

  localparam int PROB_W   = 17;
  localparam int REWARD_W = 16;
  localparam int RATE_W   = 17;
  localparam int SCORE_W  = 40;
  localparam int TOTAL_W  = 19;
  localparam int CHOSEN_W = 2;
  localparam int PADDR_W  = 4;
  localparam int PDATA_W  = 32;

  localparam int DIV_N_DEF = 58;
  localparam int DIV_D_DEF = 42;

  localparam logic [PROB_W-1:0]   PROB_INIT = 17'd16384;
  localparam logic [RATE_W-1:0]   ONE_Q16   = 17'd65536;
  localparam logic [REWARD_W-1:0] SCORE_BEST_RST     = 16'd33;
  localparam logic [REWARD_W-1:0] SCORE_BETTER_RST   = 16'd9;
  localparam logic [REWARD_W-1:0] SCORE_ACCEPTED_RST = 16'd13;
  localparam logic [RATE_W-1:0]   SMOOTHING_RATE_RST = 17'd6554;

  typedef enum logic [1:0] {
    ACT_RESET  = 2'd0,
    ACT_RECORD = 2'd1,
    ACT_UPDATE = 2'd2,
    ACT_SELECT = 2'd3
  } act_t;

  typedef enum logic [1:0] {
    REG_SCORE_BEST     = 2'd0,
    REG_SCORE_BETTER   = 2'd1,
    REG_SCORE_ACCEPTED = 2'd2,
    REG_SMOOTHING_RATE = 2'd3
  } reg_idx_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_REC_RD,
    ST_REC_WR,
    ST_UPD_RD,
    ST_UPD_MUL,
    ST_UPD_ACC,
    ST_UPD_SDIV_GO,
    ST_UPD_SDIV,
    ST_UPD_SH_GO,
    ST_UPD_SH,
    ST_UPD_BLA,
    ST_UPD_BLB,
    ST_UPD_BLW,
    ST_UPD_NRD,
    ST_UPD_N_GO,
    ST_UPD_N,
    ST_SEL_RD,
    ST_SEL_SUM,
    ST_SEL_MUL,
    ST_SEL_RD2,
    ST_SEL_CMP,
    ST_DONE
  } st_t;

  typedef struct packed {
    logic [1:0]  action;
    logic [2:0]  removal_op;
    logic [2:0]  insertion_op;
    logic [2:0]  compare_op;
    logic [1:0]  success_kind;
    logic [1:0]  op_group;
    logic [2:0]  ops_in_use;
    logic [15:0] random_fraction;
  } cmd_t;

  typedef struct packed {
    logic [CHOSEN_W-1:0] chosen_op;
    logic [TOTAL_W-1:0]  wheel_total;
  } result_t;

endpackage
`default_nettype wire

/* src/aors_ram.sv */
// Generic single-port-write, registered-read RAM
`default_nettype none
module aors_ram #(
  parameter int WIDTH = aors_pkg::PROB_W,
  parameter int DEPTH = aors_pkg::OPS_PER_GROUP_DEF * aors_pkg::GROUP_COUNT_DEF
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

/* src/aors_div.sv */
// Restoring divider, one quotient bit per cycle
`default_nettype none
module aors_div #(
  parameter int N = aors_pkg::DIV_N_DEF,
  parameter int D = aors_pkg::DIV_D_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  logic [N-1:0] dividend,
  input  logic [D-1:0] divisor,
  output logic         done,
  output logic [N-1:0] quotient
);

  localparam int CW = $clog2(N + 1);

  logic [D-1:0]  rem;
  logic [D-1:0]  dvs;
  logic [N-1:0]  quo;
  logic [CW-1:0] cnt;
  logic          run;
  logic [D:0]    trial;
  logic [D:0]    diff;
  logic          ge;

  assign trial    = {rem, quo[N-1]};
  assign diff     = trial - {1'b0, dvs};
  assign ge       = (trial >= {1'b0, dvs});
  assign quotient = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
        cnt <= CW'(N);
      end else if (run) begin
        cnt <= cnt - CW'(1);
        if (cnt == CW'(1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
      dvs <= divisor;
    end else if (run) begin
      rem <= ge ? diff[D-1:0] : trial[D-1:0];
      quo <= {quo[N-2:0], ge};
    end
  end

endmodule
`default_nettype wire

/* src/adaptive_operator_roulette_selector.sv */
// Adaptive operator roulette selector: top level, sequencer and datapath
// Each command word runs from its accept cycle to its result strobe. A select whose group is out
// of range or whose wheel is empty goes straight to the strobe. An update is paced by the one
// shared restoring divider, doing up to three divisions per operator. One word at a time: busy
// stays high until the result strobe; results cannot be stalled.
// Reset clears control, config and valid bits; entries read as reset values until written.
`default_nettype none
module adaptive_operator_roulette_selector #(
  parameter int OPS_PER_GROUP = aors_pkg::OPS_PER_GROUP_DEF,
  parameter int GROUP_COUNT   = aors_pkg::GROUP_COUNT_DEF,
  parameter int SUCCESS_KINDS = aors_pkg::SUCCESS_KINDS_DEF,
  parameter int TALLY_WIDTH   = aors_pkg::TALLY_WIDTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [aors_pkg::PADDR_W-1:0] paddr,
  input  logic [aors_pkg::PDATA_W-1:0] pwdata,
  output logic [aors_pkg::PDATA_W-1:0] prdata,
  output logic                         pready,
  input  logic                         start,
  output logic                         busy,
  input  aors_pkg::cmd_t               cmd,
  output logic                         done,
  output aors_pkg::result_t            result
);

  localparam int ROWS       = GROUP_COUNT * OPS_PER_GROUP;
  localparam int AW         = $clog2(ROWS);
  localparam int OW         = $clog2(OPS_PER_GROUP);
  localparam int NW         = OW + 1;
  localparam int GW         = (GROUP_COUNT > 1) ? $clog2(GROUP_COUNT) : 1;
  localparam int KW         = (SUCCESS_KINDS > 1) ? $clog2(SUCCESS_KINDS) : 1;
  localparam int REC_GROUPS = (GROUP_COUNT < 3) ? GROUP_COUNT : 3;
  localparam int ROW_W      = TALLY_WIDTH * (SUCCESS_KINDS + 1);
  localparam int PROD_W     = TALLY_WIDTH + aors_pkg::REWARD_W;
  localparam int NUM_W      = PROD_W + 2;
  localparam int SCORE_W    = aors_pkg::SCORE_W;
  localparam int PROB_W     = aors_pkg::PROB_W;
  localparam int SSUM_W     = SCORE_W + OW;
  localparam int PSUM_W     = PROB_W + OW;
  localparam int BL_W       = 2 * PROB_W;
  localparam int DIV_N      = (NUM_W + 16 > SCORE_W + 16) ? NUM_W + 16 : SCORE_W + 16;
  localparam int DIV_D      = (SSUM_W > TALLY_WIDTH) ? SSUM_W : TALLY_WIDTH;
  localparam int TGT_W      = PSUM_W + 16;

  // configuration
  logic [aors_pkg::REWARD_W-1:0] score_best;
  logic [aors_pkg::REWARD_W-1:0] score_better;
  logic [aors_pkg::REWARD_W-1:0] score_accepted;
  logic [aors_pkg::RATE_W-1:0]   smoothing_rate;
  logic                          cfg_we;
  aors_pkg::reg_idx_t            cfg_idx;

  assign pready  = 1'b1;
  assign cfg_we  = psel & penable & pwrite & pready;
  assign cfg_idx = aors_pkg::reg_idx_t'(paddr[3:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      score_best     <= aors_pkg::SCORE_BEST_RST;
      score_better   <= aors_pkg::SCORE_BETTER_RST;
      score_accepted <= aors_pkg::SCORE_ACCEPTED_RST;
      smoothing_rate <= aors_pkg::SMOOTHING_RATE_RST;
    end else if (cfg_we) begin
      case (cfg_idx)
        aors_pkg::REG_SCORE_BEST:     score_best     <= pwdata[aors_pkg::REWARD_W-1:0];
        aors_pkg::REG_SCORE_BETTER:   score_better   <= pwdata[aors_pkg::REWARD_W-1:0];
        aors_pkg::REG_SCORE_ACCEPTED: score_accepted <= pwdata[aors_pkg::REWARD_W-1:0];
        aors_pkg::REG_SMOOTHING_RATE: smoothing_rate <= pwdata[aors_pkg::RATE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      aors_pkg::REG_SCORE_BEST:     prdata = aors_pkg::PDATA_W'(score_best);
      aors_pkg::REG_SCORE_BETTER:   prdata = aors_pkg::PDATA_W'(score_better);
      aors_pkg::REG_SCORE_ACCEPTED: prdata = aors_pkg::PDATA_W'(score_accepted);
      aors_pkg::REG_SMOOTHING_RATE: prdata = aors_pkg::PDATA_W'(smoothing_rate);
      default:                      prdata = '0;
    endcase
  end

  // sequencer and datapath registers
  aors_pkg::st_t       state, state_next;
  aors_pkg::cmd_t      cmd_q;
  logic [GW-1:0]       g;
  logic [OW-1:0]       i;
  logic [KW-1:0]       k;
  logic [NW-1:0]       n_eff;
  logic [NUM_W-1:0]    acc;
  logic [PROD_W-1:0]   prod_q;
  logic                prod_v;
  logic [SCORE_W-1:0]  sc [OPS_PER_GROUP];
  logic [SSUM_W-1:0]   ssum;
  logic [PSUM_W-1:0]   psum;
  logic [PROB_W-1:0]   share_q;
  logic [PROB_W-1:0]   p_q;
  logic [BL_W-1:0]     bl_a;
  logic [BL_W-1:0]     bl_b;
  logic [PSUM_W-1:0]   total;
  logic [PSUM_W-1:0]   target;
  logic [PSUM_W-1:0]   run;
  logic                found;
  logic [aors_pkg::CHOSEN_W-1:0] chosen;

  // memories and their valid bits
  logic [ROWS-1:0]   row_valid;
  logic [ROWS-1:0]   prob_valid;
  logic              row_rv;
  logic              prob_rv;
  logic              row_re, row_we, prob_re, prob_we;
  logic [AW-1:0]     addr;
  logic [ROW_W-1:0]  row_rdata, row_rd, row_init, row_upd;
  logic [PROB_W-1:0] prob_rdata, prob_rd, prob_wdata;

  // divider
  logic              div_start, div_done;
  logic [DIV_N-1:0]  div_dividend, div_quo;
  logic [DIV_D-1:0]  div_divisor;

  // helpers
  logic                        accept;
  logic [2:0]                  cur_op;
  logic                        rec_hit;
  logic [OW-1:0]               idx;
  logic                        last_i, last_g, last_rec_g, last_k, sel_last;
  logic [TALLY_WIDTH-1:0]      tally_k, cnt_div;
  logic [aors_pkg::REWARD_W-1:0] reward_k;
  logic [PROD_W-1:0]           prod_c;
  logic [SCORE_W-1:0]          score_c;
  logic [SSUM_W-1:0]           ssum_next;
  logic [aors_pkg::RATE_W-1:0] rate_sat, one_minus;
  logic [BL_W:0]               bl_sum;
  logic [PROB_W-1:0]           p_new;
  logic [PSUM_W-1:0]           psum_next;
  logic [PSUM_W-1:0]           run_next;
  logic [TGT_W-1:0]            tgt_c;

  assign accept = start & ~busy;
  assign busy   = (state != aors_pkg::ST_IDLE);

  always_comb begin
    case (g)
      GW'(0):  cur_op = cmd_q.removal_op;
      GW'(1):  cur_op = cmd_q.insertion_op;
      default: cur_op = cmd_q.compare_op;
    endcase
  end

  // record reads and writes back the chosen operator's row
  assign rec_hit    = (4'(cur_op) < 4'(OPS_PER_GROUP));
  assign idx        = (state == aors_pkg::ST_REC_RD || state == aors_pkg::ST_REC_WR)
                      ? cur_op[OW-1:0] : i;
  assign addr       = AW'(AW'(g) * AW'(OPS_PER_GROUP)) + AW'(idx);
  assign last_i     = (i == OW'(OPS_PER_GROUP - 1));
  assign last_g     = (g == GW'(GROUP_COUNT - 1));
  assign last_rec_g = (g == GW'(REC_GROUPS - 1));
  assign last_k     = (k == KW'(SUCCESS_KINDS - 1));
  assign sel_last   = (NW'(i) == n_eff - NW'(1));

  always_comb begin
    for (int kk = 0; kk <= SUCCESS_KINDS; kk++) begin
      row_init[kk*TALLY_WIDTH +: TALLY_WIDTH] = TALLY_WIDTH'(1);
    end
  end

  assign row_rd  = row_rv ? row_rdata : row_init;
  assign prob_rd = prob_rv ? prob_rdata : aors_pkg::PROB_INIT;

  // saturating bumps of the count and of the credited tally
  always_comb begin
    logic [TALLY_WIDTH-1:0] f;
    row_upd = row_rd;
    f = row_rd[TALLY_WIDTH-1:0];
    row_upd[TALLY_WIDTH-1:0] = (&f) ? f : f + TALLY_WIDTH'(1);
    for (int kk = 0; kk < SUCCESS_KINDS; kk++) begin
      f = row_rd[(kk+1)*TALLY_WIDTH +: TALLY_WIDTH];
      if (cmd_q.success_kind == 2'(kk)) begin
        row_upd[(kk+1)*TALLY_WIDTH +: TALLY_WIDTH] = (&f) ? f : f + TALLY_WIDTH'(1);
      end
    end
  end

  always_comb begin
    case (k)
      KW'(0):  reward_k = score_best;
      KW'(1):  reward_k = (SUCCESS_KINDS > 1) ? score_better : '0;
      KW'(2):  reward_k = (SUCCESS_KINDS > 2) ? score_accepted : '0;
      default: reward_k = '0;
    endcase
  end

  assign tally_k   = row_rd[(32'(k) + 1) * TALLY_WIDTH +: TALLY_WIDTH];
  assign prod_c    = PROD_W'(tally_k) * PROD_W'(reward_k);
  assign cnt_div   = (row_rd[TALLY_WIDTH-1:0] == '0) ? TALLY_WIDTH'(1)
                                                      : row_rd[TALLY_WIDTH-1:0];
  assign score_c   = (|div_quo[DIV_N-1:SCORE_W]) ? {SCORE_W{1'b1}} : div_quo[SCORE_W-1:0];
  assign ssum_next = ssum + SSUM_W'(score_c);
  assign rate_sat  = (smoothing_rate > aors_pkg::ONE_Q16) ? aors_pkg::ONE_Q16 : smoothing_rate;
  assign one_minus = aors_pkg::ONE_Q16 - rate_sat;
  assign bl_sum    = (BL_W+1)'(bl_a) + (BL_W+1)'(bl_b);
  assign p_new     = bl_sum[16 +: PROB_W];
  assign psum_next = psum + PSUM_W'(p_new);
  assign run_next  = run + PSUM_W'(prob_rd);
  assign tgt_c     = TGT_W'(cmd_q.random_fraction) * TGT_W'(total);

  // next state and memory / divider controls
  always_comb begin
    state_next   = state;
    row_re       = 1'b0;
    row_we       = 1'b0;
    prob_re      = 1'b0;
    prob_we      = 1'b0;
    prob_wdata   = p_new;
    div_start    = 1'b0;
    div_dividend = '0;
    div_divisor  = '0;
    case (state)
      aors_pkg::ST_IDLE: begin
        if (accept) begin
          case (aors_pkg::act_t'(cmd.action))
            aors_pkg::ACT_RESET:  state_next = aors_pkg::ST_DONE;
            aors_pkg::ACT_RECORD: state_next = aors_pkg::ST_REC_RD;
            aors_pkg::ACT_UPDATE: state_next = aors_pkg::ST_UPD_RD;
            aors_pkg::ACT_SELECT: begin
              if (32'(cmd.op_group) < GROUP_COUNT && cmd.ops_in_use != 3'd0) begin
                state_next = aors_pkg::ST_SEL_RD;
              end else begin
                state_next = aors_pkg::ST_DONE;
              end
            end
            default: state_next = aors_pkg::ST_DONE;
          endcase
        end
      end
      aors_pkg::ST_REC_RD: begin
        if (rec_hit) begin
          row_re     = 1'b1;
          state_next = aors_pkg::ST_REC_WR;
        end else if (last_rec_g) begin
          state_next = aors_pkg::ST_DONE;
        end
      end
      aors_pkg::ST_REC_WR: begin
        row_we     = 1'b1;
        state_next = last_rec_g ? aors_pkg::ST_DONE : aors_pkg::ST_REC_RD;
      end
      aors_pkg::ST_UPD_RD: begin
        row_re     = 1'b1;
        state_next = aors_pkg::ST_UPD_MUL;
      end
      aors_pkg::ST_UPD_MUL: begin
        if (last_k) begin
          state_next = aors_pkg::ST_UPD_ACC;
        end
      end
      aors_pkg::ST_UPD_ACC: state_next = aors_pkg::ST_UPD_SDIV_GO;
      aors_pkg::ST_UPD_SDIV_GO: begin
        div_start    = 1'b1;
        div_dividend = DIV_N'({acc, 16'h0000});
        div_divisor  = DIV_D'(cnt_div);
        state_next   = aors_pkg::ST_UPD_SDIV;
      end
      aors_pkg::ST_UPD_SDIV: begin
        if (div_done) begin
          if (!last_i) begin
            state_next = aors_pkg::ST_UPD_RD;
          end else if (ssum_next != '0) begin
            state_next = aors_pkg::ST_UPD_SH_GO;
          end else begin
            state_next = last_g ? aors_pkg::ST_DONE : aors_pkg::ST_UPD_RD;
          end
        end
      end
      aors_pkg::ST_UPD_SH_GO: begin
        div_start    = 1'b1;
        div_dividend = DIV_N'({sc[i], 16'h0000});
        div_divisor  = DIV_D'(ssum);
        prob_re      = 1'b1;
        state_next   = aors_pkg::ST_UPD_SH;
      end
      aors_pkg::ST_UPD_SH: begin
        if (div_done) begin
          state_next = aors_pkg::ST_UPD_BLA;
        end
      end
      aors_pkg::ST_UPD_BLA: state_next = aors_pkg::ST_UPD_BLB;
      aors_pkg::ST_UPD_BLB: state_next = aors_pkg::ST_UPD_BLW;
      aors_pkg::ST_UPD_BLW: begin
        prob_we = 1'b1;
        if (!last_i) begin
          state_next = aors_pkg::ST_UPD_SH_GO;
        end else if (psum_next != '0) begin
          state_next = aors_pkg::ST_UPD_NRD;
        end else begin
          state_next = last_g ? aors_pkg::ST_DONE : aors_pkg::ST_UPD_RD;
        end
      end
      aors_pkg::ST_UPD_NRD: begin
        prob_re    = 1'b1;
        state_next = aors_pkg::ST_UPD_N_GO;
      end
      aors_pkg::ST_UPD_N_GO: begin
        div_start    = 1'b1;
        div_dividend = DIV_N'({prob_rd, 16'h0000});
        div_divisor  = DIV_D'(psum);
        state_next   = aors_pkg::ST_UPD_N;
      end
      aors_pkg::ST_UPD_N: begin
        prob_wdata = div_quo[PROB_W-1:0];
        if (div_done) begin
          prob_we = 1'b1;
          if (!last_i) begin
            state_next = aors_pkg::ST_UPD_NRD;
          end else begin
            state_next = last_g ? aors_pkg::ST_DONE : aors_pkg::ST_UPD_RD;
          end
        end
      end
      aors_pkg::ST_SEL_RD: begin
        prob_re    = 1'b1;
        state_next = aors_pkg::ST_SEL_SUM;
      end
      aors_pkg::ST_SEL_SUM: state_next = sel_last ? aors_pkg::ST_SEL_MUL : aors_pkg::ST_SEL_RD;
      aors_pkg::ST_SEL_MUL: state_next = aors_pkg::ST_SEL_RD2;
      aors_pkg::ST_SEL_RD2: begin
        prob_re    = 1'b1;
        state_next = aors_pkg::ST_SEL_CMP;
      end
      aors_pkg::ST_SEL_CMP: state_next = sel_last ? aors_pkg::ST_DONE : aors_pkg::ST_SEL_RD2;
      aors_pkg::ST_DONE:    state_next = aors_pkg::ST_IDLE;
      default:              state_next = aors_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= aors_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // valid bits: a row that is not valid reads as its reset value
  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid  <= '0;
      prob_valid <= '0;
      row_rv     <= 1'b0;
      prob_rv    <= 1'b0;
    end else begin
      if (accept && cmd.action == aors_pkg::ACT_RESET) begin
        row_valid <= '0;
      end else if (row_we) begin
        row_valid[addr] <= 1'b1;
      end
      if (prob_we) begin
        prob_valid[addr] <= 1'b1;
      end
      if (row_re) begin
        row_rv <= row_valid[addr];
      end
      if (prob_re) begin
        prob_rv <= prob_valid[addr];
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state)
      aors_pkg::ST_IDLE: begin
        if (accept) begin
          cmd_q  <= cmd;
          g      <= (cmd.action == aors_pkg::ACT_SELECT) ? GW'(cmd.op_group) : '0;
          i      <= '0;
          ssum   <= '0;
          psum   <= '0;
          total  <= '0;
          run    <= '0;
          found  <= 1'b0;
          chosen <= '0;
          n_eff  <= (32'(cmd.ops_in_use) > OPS_PER_GROUP) ? NW'(OPS_PER_GROUP)
                                                         : NW'(cmd.ops_in_use);
        end
      end
      aors_pkg::ST_REC_RD: begin
        if (!rec_hit) begin
          g <= g + GW'(1);
        end
      end
      aors_pkg::ST_REC_WR: g <= g + GW'(1);
      aors_pkg::ST_UPD_RD: begin
        k      <= '0;
        acc    <= '0;
        prod_v <= 1'b0;
      end
      aors_pkg::ST_UPD_MUL: begin
        prod_q <= prod_c;
        prod_v <= 1'b1;
        if (prod_v) begin
          acc <= acc + NUM_W'(prod_q);
        end
        k <= k + KW'(1);
      end
      aors_pkg::ST_UPD_ACC: acc <= acc + NUM_W'(prod_q);
      aors_pkg::ST_UPD_SDIV: begin
        if (div_done) begin
          sc[i] <= score_c;
          ssum  <= ssum_next;
          i     <= i + OW'(1);
          if (last_i && ssum_next == '0) begin
            g    <= g + GW'(1);
            ssum <= '0;
            psum <= '0;
          end
        end
      end
      aors_pkg::ST_UPD_SH: begin
        if (div_done) begin
          share_q <= div_quo[PROB_W-1:0];
          p_q     <= prob_rd;
        end
      end
      aors_pkg::ST_UPD_BLA: bl_a <= BL_W'(p_q) * BL_W'(one_minus);
      aors_pkg::ST_UPD_BLB: bl_b <= BL_W'(rate_sat) * BL_W'(share_q);
      aors_pkg::ST_UPD_BLW: begin
        psum <= psum_next;
        i    <= i + OW'(1);
        if (last_i && psum_next == '0) begin
          g    <= g + GW'(1);
          ssum <= '0;
          psum <= '0;
        end
      end
      aors_pkg::ST_UPD_N: begin
        if (div_done) begin
          i <= i + OW'(1);
          if (last_i) begin
            g    <= g + GW'(1);
            ssum <= '0;
            psum <= '0;
          end
        end
      end
      aors_pkg::ST_SEL_SUM: begin
        total <= total + PSUM_W'(prob_rd);
        i     <= sel_last ? '0 : i + OW'(1);
      end
      aors_pkg::ST_SEL_MUL: target <= tgt_c[16 +: PSUM_W];
      aors_pkg::ST_SEL_CMP: begin
        run <= run_next;
        if (!found && target < run_next) begin
          chosen <= aors_pkg::CHOSEN_W'(i);
          found  <= 1'b1;
        end
        i <= i + OW'(1);
      end
      default: ;
    endcase
  end

  assign done               = (state == aors_pkg::ST_DONE);
  assign result.chosen_op   = chosen;
  assign result.wheel_total = aors_pkg::TOTAL_W'(total);

  aors_ram #(.WIDTH(ROW_W), .DEPTH(ROWS)) u_row_ram (
    .clk   (clk),
    .we    (row_we),
    .waddr (addr),
    .wdata (row_upd),
    .re    (row_re),
    .raddr (addr),
    .rdata (row_rdata)
  );

  aors_ram #(.WIDTH(PROB_W), .DEPTH(ROWS)) u_prob_ram (
    .clk   (clk),
    .we    (prob_we),
    .waddr (addr),
    .wdata (prob_wdata),
    .re    (prob_re),
    .raddr (addr),
    .rdata (prob_rdata)
  );

  aors_div #(.N(DIV_N), .D(DIV_D)) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_quo)
  );

endmodule
`default_nettype wire

/* src/aors_chk.sv */
// Port-level checker for the operator roulette selector, bound to the top level
`default_nettype none
`include "adaptive_operator_roulette_selector_defines.svh"
module aors_chk (
  input logic clk,
  input logic rst,
  input logic psel,
  input logic penable,
  input logic pready,
  input logic start,
  input logic busy,
  input logic done
);

  `AORS_ASSERT_NEXT(a_accept_goes_busy, start && !busy, busy)
  `AORS_ASSERT_NEXT(a_done_single_cycle, done, !done)
  `AORS_ASSERT_NOW(a_done_while_busy, done, busy)
  `AORS_ASSERT_NOW(a_idle_only_after_word, $fell(busy), $past(done))
  `AORS_ASSERT_NOW(a_apb_no_wait, psel && penable, pready)

endmodule

bind adaptive_operator_roulette_selector aors_chk u_aors_chk (.*);
`default_nettype wire

/* tb/sv/tb_adaptive_operator_roulette_selector.sv */
// Testbench for the adaptive operator roulette selector: driver, predictor and checks
`timescale 1ns / 100ps
module tb_adaptive_operator_roulette_selector;
  import aors_pkg::*;

  localparam int OPS      = 4;
  localparam int GROUPS   = 3;
  localparam int KINDS    = 3;
  localparam longint unsigned TALLY_TOP = (64'd1 << 24) - 1;
  localparam longint unsigned SCORE_TOP = (64'd1 << 40) - 1;
  localparam int STALL_LIMIT = 40000;

  class selector_scoreboard;
    bit [63:0] rewards[KINDS];
    bit [63:0] rate;
    bit [63:0] counts[GROUPS*OPS];
    bit [63:0] tallies[GROUPS*OPS*KINDS];
    bit [63:0] probs[GROUPS*OPS];
    result_t   pending[$];
    int        failures;
    int        checked;

    function new();
      rewards[0] = SCORE_BEST_RST;
      rewards[1] = SCORE_BETTER_RST;
      rewards[2] = SCORE_ACCEPTED_RST;
      rate = SMOOTHING_RATE_RST;
      clear_tallies();
      foreach (probs[i]) probs[i] = PROB_INIT;
      failures = 0;
      checked = 0;
    endfunction

    function void clear_tallies();
      foreach (counts[i]) counts[i] = 1;
      foreach (tallies[i]) tallies[i] = 1;
    endfunction

    function void set_reg(reg_idx_t idx, bit [31:0] val);
      case (idx)
        REG_SCORE_BEST:     rewards[0] = val[15:0];
        REG_SCORE_BETTER:   rewards[1] = val[15:0];
        REG_SCORE_ACCEPTED: rewards[2] = val[15:0];
        default:            rate = val[16:0];
      endcase
    endfunction

    function bit [63:0] op_score(int idx);
      bit [63:0] num, cnt, q, r;
      num = 0;
      for (int k = 0; k < KINDS; k++) num += tallies[idx*KINDS+k] * rewards[k];
      cnt = (counts[idx] == 0) ? 1 : counts[idx];
      q = num / cnt;
      r = num % cnt;
      if (q >= (64'd1 << 24)) return SCORE_TOP;
      return (q << 16) + ((r << 16) / cnt);
    endfunction

    function void reweigh_group(int g);
      bit [63:0] sc[OPS];
      bit [63:0] ssum, psum, r, share, p;
      int base;
      base = g * OPS;
      ssum = 0;
      psum = 0;
      r = (rate > 65536) ? 65536 : rate;
      for (int i = 0; i < OPS; i++) begin
        sc[i] = op_score(base + i);
        ssum += sc[i];
      end
      if (ssum == 0) return;
      for (int i = 0; i < OPS; i++) begin
        share = (sc[i] << 16) / ssum;
        p = (probs[base+i] * (65536 - r) + r * share) >> 16;
        probs[base+i] = p;
        psum += p;
      end
      if (psum == 0) return;
      for (int i = 0; i < OPS; i++) probs[base+i] = ((probs[base+i] << 16) / psum) & 64'h1FFFF;
    endfunction

    // accepted command word: advance the state and queue the expected result
    function void note_command(cmd_t c);
      bit [2:0]  ops[GROUPS];
      bit [63:0] total, target, run, n;
      int        idx, base;
      result_t   res;
      res = '0;
      total = 0;
      ops[0] = c.removal_op;
      ops[1] = c.insertion_op;
      ops[2] = c.compare_op;
      case (act_t'(c.action))
        ACT_RESET: clear_tallies();
        ACT_RECORD: begin
          for (int g = 0; g < GROUPS; g++) begin
            if (ops[g] < OPS) begin
              idx = g * OPS + ops[g];
              if (counts[idx] < TALLY_TOP) counts[idx]++;
              if (c.success_kind < KINDS && tallies[idx*KINDS+c.success_kind] < TALLY_TOP)
                tallies[idx*KINDS+c.success_kind]++;
            end
          end
        end
        ACT_UPDATE: for (int g = 0; g < GROUPS; g++) reweigh_group(g);
        default: begin
          n = c.ops_in_use;
          if (c.op_group < GROUPS && n > 0) begin
            if (n > OPS) n = OPS;
            base = c.op_group * OPS;
            for (int i = 0; i < n; i++) total += probs[base+i];
            target = (c.random_fraction * total) >> 16;
            run = 0;
            for (int i = 0; i < n; i++) begin
              run += probs[base+i];
              if (target < run) begin
                res.chosen_op = 2'(i);
                break;
              end
            end
          end
        end
      endcase
      res.wheel_total = total[TOTAL_W-1:0];
      pending = {pending, res};
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (pending.size() == 0) begin
        $error("result word with nothing expected: chosen_op %0d wheel_total %0d",
               got.chosen_op, got.wheel_total);
        failures++;
        return;
      end
      want = pending.pop_front();
      checked++;
      if (got.chosen_op !== want.chosen_op) begin
        $error("chosen_op expected %0d actual %0d", want.chosen_op, got.chosen_op);
        failures++;
      end
      if (got.wheel_total !== want.wheel_total) begin
        $error("wheel_total expected %0d actual %0d", want.wheel_total, got.wheel_total);
        failures++;
      end
    endfunction
  endclass

  logic                 clk = 0;
  logic                 rst = 1;
  logic                 psel = 0, penable = 0, pwrite = 0;
  logic [PADDR_W-1:0]   paddr = '0;
  logic [PDATA_W-1:0]   pwdata = '0;
  logic [PDATA_W-1:0]   prdata;
  logic                 pready;
  logic                 start = 0;
  logic                 busy;
  cmd_t                 cmd = '0;
  logic                 done;
  result_t              result;

  selector_scoreboard sb = new();
  int  sender_idle_pct = 0;
  int  stall_cycles = 0;
  int  words_in = 0;
  int  act_seen[4];

  always #6 clk = ~clk;

  adaptive_operator_roulette_selector i_dut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .start(start), .busy(busy), .cmd(cmd),
    .done(done), .result(result)
  );

  // monitor: note accepted words and check strobed results
  always @(posedge clk) begin
    if (!rst) begin
      if (start && !busy) begin
        sb.note_command(cmd);
        words_in++;
        act_seen[cmd.action]++;
      end
      if (done) sb.check_result(result);
      if ((start && !busy) || done) stall_cycles <= 0;
      else stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  task automatic write_reg(reg_idx_t idx, bit [31:0] val);
    @(negedge clk);
    psel <= 1;
    pwrite <= 1;
    paddr <= PADDR_W'(4 * idx);
    pwdata <= val;
    @(negedge clk);
    penable <= 1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    sb.set_reg(idx, val);
    @(negedge clk);
    psel <= 0;
    penable <= 0;
    pwrite <= 0;
  endtask

  task automatic configure(bit [31:0] best, bit [31:0] better, bit [31:0] acc,
                           bit [31:0] r);
    write_reg(REG_SCORE_BEST, best);
    write_reg(REG_SCORE_BETTER, better);
    write_reg(REG_SCORE_ACCEPTED, acc);
    write_reg(REG_SMOOTHING_RATE, r);
  endtask

  // start is raised at a falling edge and held until the word is taken
  task automatic send(cmd_t c);
    while ($urandom_range(99) < sender_idle_pct) begin
      @(negedge clk);
      start <= 0;
    end
    @(negedge clk);
    start <= 1;
    cmd <= c;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic drain();
    @(negedge clk);
    start <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  function automatic cmd_t rand_cmd();
    cmd_t c;
    int   w;
    c = cmd_t'($bits(cmd_t)'({$urandom, $urandom}));
    w = $urandom_range(99);
    if (w < 3) c.action = ACT_RESET;
    else if (w < 58) c.action = ACT_RECORD;
    else if (w < 66) c.action = ACT_UPDATE;
    else c.action = ACT_SELECT;
    // mostly real operators, groups and wheel sizes; the rest random, so possibly out of range
    if ($urandom_range(9) < 8) begin
      c.removal_op = 3'($urandom_range(3));
      c.insertion_op = 3'($urandom_range(3));
      c.compare_op = 3'($urandom_range(3));
      c.op_group = 2'($urandom_range(2));
      c.ops_in_use = 3'($urandom_range(4, 1));
    end
    return c;
  endfunction

  function automatic cmd_t mk(act_t a, bit [2:0] rop, bit [2:0] iop, bit [2:0] cop,
                              bit [1:0] kind, bit [1:0] grp, bit [2:0] n, bit [15:0] frac);
    cmd_t c;
    c.action = a;
    c.removal_op = rop;
    c.insertion_op = iop;
    c.compare_op = cop;
    c.success_kind = kind;
    c.op_group = grp;
    c.ops_in_use = n;
    c.random_fraction = frac;
    return c;
  endfunction

  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 0;

    // directed: extremes of every field, every action and the corner cases
    send(mk(ACT_SELECT, 0, 0, 0, 0, 0, 4, 16'h0000));
    send(mk(ACT_SELECT, 0, 0, 0, 0, 2, 4, 16'hFFFF));
    send(mk(ACT_SELECT, 0, 0, 0, 0, 3, 4, 16'h8000));  // group out of range
    send(mk(ACT_SELECT, 0, 0, 0, 0, 1, 0, 16'h8000));  // empty wheel
    send(mk(ACT_SELECT, 0, 0, 0, 0, 1, 7, 16'hC000));  // oversize wheel
    send(mk(ACT_RECORD, 0, 3, 2, 0, 0, 1, 16'h1234));
    send(mk(ACT_RECORD, 3, 0, 1, 1, 0, 1, 16'h0));
    send(mk(ACT_RECORD, 1, 2, 3, 2, 0, 1, 16'h0));
    send(mk(ACT_RECORD, 4, 7, 5, 3, 3, 7, 16'hFFFF));  // no operators, no credit
    send(mk(ACT_RECORD, 2, 6, 0, 3, 0, 1, 16'h0));
    send(mk(ACT_UPDATE, 7, 7, 7, 3, 3, 7, 16'hFFFF));
    send(mk(ACT_SELECT, 0, 0, 0, 0, 0, 1, 16'hFFFF));
    send(mk(ACT_SELECT, 0, 0, 0, 0, 0, 3, 16'h7FFF));
    send(mk(ACT_RESET, 7, 7, 7, 3, 3, 7, 16'hFFFF));
    send(mk(ACT_SELECT, 0, 0, 0, 0, 0, 4, 16'hA000));
    drain();
    // zero rewards: score sum is zero, blend skipped
    configure(0, 0, 0, 65536);
    send(mk(ACT_RECORD, 1, 1, 1, 0, 0, 1, 16'h0));
    send(mk(ACT_UPDATE, 0, 0, 0, 0, 0, 1, 16'h0));
    send(mk(ACT_SELECT, 0, 0, 0, 0, 1, 4, 16'h4000));
    drain();
    // full rate, top rewards, then an oversized rate that saturates to one
    configure(16'hFFFF, 16'hFFFF, 16'hFFFF, 65536);
    send(mk(ACT_RECORD, 3, 3, 3, 0, 0, 1, 16'h0));
    send(mk(ACT_UPDATE, 0, 0, 0, 0, 0, 1, 16'h0));
    send(mk(ACT_SELECT, 0, 0, 0, 0, 2, 4, 16'hFFFF));
    drain();
    configure(0, 16'hFFFF, 1, 17'h1FFFF);
    send(mk(ACT_UPDATE, 0, 0, 0, 0, 0, 1, 16'h0));
    send(mk(ACT_SELECT, 0, 0, 0, 0, 0, 4, 16'hFFFF));
    drain();

    // random phases, cycling through four kinds of settings and four sender idling rates
    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: configure(SCORE_BEST_RST, SCORE_BETTER_RST, SCORE_ACCEPTED_RST,
                     SMOOTHING_RATE_RST);
        1: configure($urandom_range(65535), $urandom_range(65535), $urandom_range(65535),
                     $urandom_range(65536));
        2: configure($urandom_range(3), $urandom_range(3), 0, 0);
        default: configure(16'hFFFF, 0, $urandom_range(500), 65536);
      endcase
      case (ph % 4)
        0: sender_idle_pct = 0;
        1: sender_idle_pct = 73;
        2: sender_idle_pct = 9;
        default: sender_idle_pct = 40;
      endcase
      repeat (235) send(rand_cmd());
      drain();
    end

    repeat (20) @(posedge clk);
    $display("Run covered %0d words (reset %0d, record %0d, update %0d, select %0d),",
             words_in, act_seen[0], act_seen[1], act_seen[2], act_seen[3]);
    $display("%0d results checked under eight register settings and four idling mixes.",
             sb.checked);
    if (sb.failures == 0 && sb.pending.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
